// File: sv/rcptx_pkg.sv
// ----------------------------------------------------------------------------
// rcptx_pkg
// Shared constants and types of the pulse transmit block: bus map, operation
// codes and the request/response bundle of the remainder unit.
// ----------------------------------------------------------------------------
package rcptx_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [11:0] ADDR_CONF     = 12'h020;
    localparam logic [11:0] ADDR_INT_RAW  = 12'h0A0;
    localparam logic [11:0] ADDR_INT_ST   = 12'h0A4;
    localparam logic [11:0] ADDR_INT_ENA  = 12'h0A8;
    localparam logic [11:0] ADDR_INT_CLR  = 12'h0AC;
    localparam logic [11:0] ADDR_TX_LIM   = 12'h0D0;
    localparam logic [11:0] ADDR_BUS_CONF = 12'h0F0;
    localparam logic [11:0] ADDR_MEM      = 12'h800;

    localparam int BLOCK_WORDS = 64;
    localparam int DIVIDEND_W  = 26;
    localparam int DIVISOR_W   = 4;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] rem;
    } mod_rsp_t;

endpackage

// File: sv/rcptx_if.sv
// ----------------------------------------------------------------------------
// rcptx_if
// Valid/ready channels of the pulse transmit block: bus request and result.
// ----------------------------------------------------------------------------
interface rcptx_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [11:0] address;
    logic [31:0] write_data;

    modport source (output valid, operation, address, write_data, input ready);
    modport sink (input valid, operation, address, write_data, output ready);
endinterface

interface rcptx_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] read_data;
    logic [31:0] tx_word;
    logic [2:0]  tx_channel;
    logic        irq;
    logic        last;

    modport source (output valid, kind, read_data, tx_word, tx_channel, irq, last,
                    input ready);
    modport sink (input valid, kind, read_data, tx_word, tx_channel, irq, last,
                  output ready);
endinterface

// File: sv/rcptx_ram.sv
// ----------------------------------------------------------------------------
// rcptx_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rcptx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/rcptx_modu.sv
// ----------------------------------------------------------------------------
// rcptx_modu
// Bit-serial remainder unit: one restoring step per cycle over the dividend.
// ----------------------------------------------------------------------------
module rcptx_modu (
    input  logic               clk,
    input  logic               rst_n,
    input  rcptx_pkg::mod_req_t req,
    output rcptx_pkg::mod_rsp_t rsp
);
    import rcptx_pkg::*;

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] shift_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DIVISOR_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                shift_reg <= req.dividend;
                div_reg   <= req.divisor;
                rem_reg   <= '0;
                cnt_reg   <= CW'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next;
                shift_reg <= shift_reg << 1;
                cnt_reg   <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: sv/remote_control_pulse_tx_channels_core.sv
// ----------------------------------------------------------------------------
// remote_control_pulse_tx_channels_core
// Eight-channel pulse transmit peripheral behind a bus register map.
// ----------------------------------------------------------------------------
// usage:
//   req carries one bus operation per transfer: read, write or timer tick.
//   rsp returns the results of that operation: one transfer per pulse word
//   sent (kind 1), then always one completion (kind 0, last 1) that holds
//   read data and the interrupt line level.
//   a tick (or an interrupt clear with a deferred send) walks the channels
//   in order: idle and deferred channels are passed over, and each
//   started channel runs the 26-step offset remainder, then reads and
//   sends its pulse words, taking the memory index modulo MEM_WORDS.
//   one operation is handled at a time; req.ready stays low until its
//   completion has been loaded into the output register.
//   after reset the pulse memory is swept to zero, one word a cycle, over
//   all MEM_WORDS words, with req.ready low.
//   a stalled rsp holds its transfer; the sequencer waits for space.
// ----------------------------------------------------------------------------
module remote_control_pulse_tx_channels_core #(
    parameter int NUM_CHANNELS = 8,
    parameter int MEM_WORDS    = 512,
    parameter int MAX_BURST    = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    rcptx_req_if.sink          req,
    rcptx_rsp_if.source        rsp
);
    import rcptx_pkg::*;

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHW = CIW + 1;
    localparam int LW  = $clog2(MAX_BURST + 1);
    localparam logic [11:0] CONF_END = 12'(32'(ADDR_CONF) + 8 * NUM_CHANNELS - 4);
    localparam logic [11:0] LIM_END  = 12'(32'(ADDR_TX_LIM) + 4 * NUM_CHANNELS - 1);
    localparam logic [12:0] MEM_END  = 13'(32'(ADDR_MEM) + 4 * MEM_WORDS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_MEMRD, S_CHAN, S_MOD,
        S_WORD, S_IDXM, S_RDW, S_EMIT, S_DONE
    } state_t;

    state_t state_reg;
    state_t exec_state;

    logic [31:0] conf_a_reg [NUM_CHANNELS];
    logic [31:0] conf_b_reg [NUM_CHANNELS];
    logic [31:0] limit_reg  [NUM_CHANNELS];
    logic [31:0] raw_reg;
    logic [31:0] ena_reg;
    logic [31:0] offset_reg;
    logic [31:0] bus_conf_reg;
    logic        irq_reg;
    logic        pending_reg;

    logic [1:0]  op_reg;
    logic [11:0] addr_reg;
    logic [31:0] data_reg;
    logic [31:0] rd_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [CHW-1:0] ch_reg;
    logic [3:0]     k_reg;
    logic [LW-1:0]  lim_reg;
    logic [LW-1:0]  i_reg;
    logic [31:0]    cnt_reg;
    logic [9:0]     r_reg;
    logic [10:0]    idx_reg;
    logic [31:0]    word_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [31:0] out_rd_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_ch_reg;
    logic        out_irq_reg;
    logic        out_last_reg;

    logic            in_conf;
    logic            in_lim;
    logic            in_mem;
    logic [11:0]     conf_off;
    logic [11:0]     lim_off;
    logic [11:0]     mem_off;
    logic [CIW-1:0]  bus_ch;
    logic [CIW-1:0]  sel;
    logic [31:0]     bus_rd;
    logic [31:0]     end_mask;
    logic [31:0]     thr_mask;
    logic [3:0]      k_comb;
    logic [31:0]     raw_clr;
    logic            out_free;
    logic            out_load;
    logic            ch_start;
    logic [9:0]      r_inc;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [31:0]     ram_wdata;
    logic [31:0]     ram_rdata;

    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    always_comb
    begin
        conf_off = addr_reg - ADDR_CONF;
        lim_off  = addr_reg - ADDR_TX_LIM;
        mem_off  = addr_reg - ADDR_MEM;
        in_conf  = (addr_reg >= ADDR_CONF) && (addr_reg <= CONF_END);
        in_lim   = (addr_reg >= ADDR_TX_LIM) && (addr_reg <= LIM_END);
        in_mem   = (addr_reg >= ADDR_MEM) && ({1'b0, addr_reg} <= MEM_END);
        bus_ch   = in_conf ? CIW'(conf_off >> 3) : CIW'(lim_off >> 2);
        sel      = (state_reg == S_EXEC) ? bus_ch : ch_reg[CIW-1:0];
        end_mask = 32'b1 << (5'(ch_reg) * 5'd3);
        thr_mask = 32'b1 << (5'd24 + 5'(ch_reg));
        k_comb   = (conf_a_reg[sel][27:24] == 4'd0) ? 4'd1 : conf_a_reg[sel][27:24];
        raw_clr  = raw_reg & ~data_reg;
        out_free = !out_valid_reg || rsp.ready;
        out_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_DONE));
        ch_start = (state_reg == S_CHAN) && (ch_reg != CHW'(NUM_CHANNELS))
                   && conf_b_reg[sel][0] && ((raw_reg & (end_mask | thr_mask)) == '0);
        r_inc    = r_reg + 10'd1;

        priority if ((op_reg == OP_READ) && in_mem)
        begin
            exec_state = S_MEMRD;
        end
        else if (op_reg == OP_TICK)
        begin
            exec_state = S_CHAN;
        end
        else if ((op_reg == OP_WRITE) && (addr_reg == ADDR_INT_CLR) && pending_reg)
        begin
            exec_state = S_CHAN;
        end
        else
        begin
            exec_state = S_DONE;
        end

        priority if (in_conf)
        begin
            bus_rd = addr_reg[2] ? conf_b_reg[sel] : conf_a_reg[sel];
        end
        else if (addr_reg == ADDR_INT_RAW)
        begin
            bus_rd = raw_reg;
        end
        else if (addr_reg == ADDR_INT_ST)
        begin
            bus_rd = raw_reg & ena_reg;
        end
        else if (addr_reg == ADDR_INT_ENA)
        begin
            bus_rd = ena_reg;
        end
        else if (in_lim)
        begin
            bus_rd = limit_reg[sel];
        end
        else if (addr_reg == ADDR_BUS_CONF)
        begin
            bus_rd = bus_conf_reg;
        end
        else
        begin
            bus_rd = '0;
        end

        ram_we    = (state_reg == S_CLEAR)
                    || ((state_reg == S_EXEC) && (op_reg == OP_WRITE) && in_mem);
        ram_wdata = (state_reg == S_CLEAR) ? 32'd0 : data_reg;
        unique case (state_reg)
            S_CLEAR: ram_addr = clr_cnt_reg;
            S_EXEC:  ram_addr = AW'(mem_off >> 2);
            default: ram_addr = idx_reg[AW-1:0];
        endcase

        mod_req.start    = ch_start;
        mod_req.dividend = offset_reg[31:6];
        mod_req.divisor  = k_comb;
    end

    rcptx_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    rcptx_modu u_modu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            raw_reg       <= '0;
            ena_reg       <= '0;
            offset_reg    <= '0;
            bus_conf_reg  <= '0;
            irq_reg       <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                conf_a_reg[c] <= '0;
                conf_b_reg[c] <= '0;
                limit_reg[c]  <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MEM_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.operation;
                        addr_reg  <= req.address;
                        data_reg  <= req.write_data;
                        rd_reg    <= '0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= exec_state;
                    ch_reg    <= '0;
                    unique case (op_reg)
                        OP_READ:
                        begin
                            if (!in_mem)
                            begin
                                rd_reg <= bus_rd;
                            end
                        end
                        OP_WRITE:
                        begin
                            priority if (in_conf)
                            begin
                                if (!addr_reg[2])
                                begin
                                    conf_a_reg[sel] <= data_reg;
                                end
                                else
                                begin
                                    conf_b_reg[sel] <= data_reg;
                                    if (data_reg[3])
                                    begin
                                        offset_reg <= '0;
                                    end
                                end
                            end
                            else if (in_lim)
                            begin
                                limit_reg[sel] <= data_reg;
                            end
                            else if (addr_reg == ADDR_INT_ENA)
                            begin
                                ena_reg <= data_reg;
                            end
                            else if (addr_reg == ADDR_INT_CLR)
                            begin
                                raw_reg <= raw_clr;
                                if ((raw_clr & ena_reg) == '0)
                                begin
                                    irq_reg <= 1'b0;
                                end
                            end
                            else if (addr_reg == ADDR_BUS_CONF)
                            begin
                                bus_conf_reg <= data_reg;
                            end
                            else
                            begin
                                rd_reg <= '0;
                            end
                        end
                        default:
                        begin
                            rd_reg <= '0;
                        end
                    endcase
                end
                S_MEMRD:
                begin
                    rd_reg    <= ram_rdata;
                    state_reg <= S_DONE;
                end
                S_CHAN:
                begin
                    if (ch_reg == CHW'(NUM_CHANNELS))
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (!conf_b_reg[sel][0])
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else if ((raw_reg & (end_mask | thr_mask)) != '0)
                    begin
                        pending_reg <= 1'b1;
                        ch_reg      <= ch_reg + 1'b1;
                    end
                    else
                    begin
                        pending_reg <= 1'b0;
                        k_reg       <= k_comb;
                        lim_reg     <= (limit_reg[sel] > 32'(MAX_BURST))
                                       ? LW'(MAX_BURST) : LW'(limit_reg[sel]);
                        i_reg       <= '0;
                        cnt_reg     <= offset_reg;
                        state_reg   <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (mod_rsp.done)
                    begin
                        r_reg     <= {mod_rsp.rem, offset_reg[5:0]};
                        state_reg <= S_WORD;
                    end
                end
                S_WORD:
                begin
                    if (i_reg == lim_reg)
                    begin
                        offset_reg <= offset_reg + 32'(lim_reg);
                        raw_reg    <= raw_reg | thr_mask;
                        if ((ena_reg & thr_mask) != '0)
                        begin
                            irq_reg <= 1'b1;
                        end
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_CHAN;
                    end
                    else
                    begin
                        idx_reg   <= {1'b0, r_reg} + (11'(ch_reg) << 6);
                        state_reg <= S_IDXM;
                    end
                end
                S_IDXM:
                begin
                    if (idx_reg >= 11'(MEM_WORDS))
                    begin
                        idx_reg <= idx_reg - 11'(MEM_WORDS);
                    end
                    else
                    begin
                        state_reg <= S_RDW;
                    end
                end
                S_RDW:
                begin
                    word_reg <= ram_rdata;
                    if (ram_rdata == '0)
                    begin
                        raw_reg            <= (raw_reg | end_mask) & ~thr_mask;
                        offset_reg         <= '0;
                        conf_b_reg[sel][0] <= 1'b0;
                        if ((ena_reg & end_mask) != '0)
                        begin
                            irq_reg <= 1'b1;
                        end
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_CHAN;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= 1'b1;
                        out_rd_reg    <= '0;
                        out_word_reg  <= word_reg;
                        out_ch_reg    <= 3'(ch_reg);
                        out_irq_reg   <= irq_reg;
                        out_last_reg  <= 1'b0;
                        i_reg         <= i_reg + 1'b1;
                        cnt_reg       <= cnt_reg + 32'd1;
                        if ((cnt_reg + 32'd1) == '0 || r_inc == {k_reg, 6'd0})
                        begin
                            r_reg <= '0;
                        end
                        else
                        begin
                            r_reg <= r_inc;
                        end
                        state_reg <= S_WORD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= 1'b0;
                        out_rd_reg    <= rd_reg;
                        out_word_reg  <= '0;
                        out_ch_reg    <= '0;
                        out_irq_reg   <= irq_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.read_data  = out_rd_reg;
    assign rsp.tx_word    = out_word_reg;
    assign rsp.tx_channel = out_ch_reg;
    assign rsp.irq        = out_irq_reg;
    assign rsp.last       = out_last_reg;

endmodule

// File: sv/rcptx_checker.sv
// ----------------------------------------------------------------------------
// rcptx_checker
// Port-level checks of the pulse transmit block, bound to the top level.
// ----------------------------------------------------------------------------
module rcptx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_kind,
    input logic [31:0] rsp_tx_word,
    input logic [2:0]  rsp_tx_channel,
    input logic        rsp_last
);

    logic [1:0] open_reg;
    logic       req_fire;
    logic       done_fire;

    assign req_fire  = req_valid && req_ready;
    assign done_fire = rsp_valid && rsp_ready && rsp_last;

    // operations accepted whose completion has not been taken yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else if (req_fire && !done_fire)
        begin
            open_reg <= open_reg + 2'd1;
        end
        else if (done_fire && !req_fire)
        begin
            open_reg <= open_reg - 2'd1;
        end
    end

    // held result while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_word) && $stable(rsp_last))
        else $error("rsp transfer dropped or changed while stalled");

    // a new operation only once the previous one has handed over its completion
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> open_reg <= 2'd1)
        else $error("request accepted before previous completion");

    // no completion without a request
    assert property (@(posedge clk) disable iff (!rst_n)
        done_fire |-> open_reg != 2'd0)
        else $error("completion with no request outstanding");

    // completion is exactly the kind 0 result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_last == !rsp_kind))
        else $error("last does not mark the completion");

    // completion carries no pulse word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_kind |-> rsp_tx_word == '0 && rsp_tx_channel == '0)
        else $error("completion carries a pulse word");

endmodule

bind remote_control_pulse_tx_channels_core rcptx_checker u_rcptx_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_tx_word    (rsp.tx_word),
    .rsp_tx_channel (rsp.tx_channel),
    .rsp_last       (rsp.last)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for remote_control_pulse_tx_channels_core. A directed
// table covers reset values, unmapped and read-only registers, clamped burst
// limits, tx-end and deferred sends. Then random register traffic, pulse
// memory fills and timer ticks follow. Every response transfer is compared
// with an in-bench prediction of the register map and the channel sender.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcptx_pkg::*;

    localparam int          CHANNELS    = 8;
    localparam int          MEM_DEPTH   = 512;
    localparam int          BURST_CAP   = 7;
    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam int          TX_END_BIT  = 3;
    localparam int          THRESH_BIT  = 24;
    localparam int          RANDOM_ITEMS = 480;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          HOLD_CYCLES = 400;

    typedef struct {
        bit          kind;
        logic [31:0] read_data;
        logic [31:0] tx_word;
        logic [2:0]  tx_channel;
        bit          irq;
        bit          last;
    } result_t;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [31:0] data;
        bit          has_rd;
        logic [31:0] rd;
    } bus_op_t;

    logic clk;
    logic rst_n;

    rcptx_req_if req ();
    rcptx_rsp_if rsp ();

    remote_control_pulse_tx_channels_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predicted device state
    logic [31:0] conf_a [CHANNELS];
    logic [31:0] conf_b [CHANNELS];
    logic [31:0] burst_lim [CHANNELS];
    logic [31:0] pulse_mem [MEM_DEPTH];
    logic [31:0] int_raw;
    logic [31:0] int_ena;
    logic [31:0] send_offset;
    logic [31:0] bus_conf;
    bit          irq_line;
    bit          send_deferred;

    result_t pending_results [$];
    int      mismatches;
    int      words_sent;
    int      ticks_run;
    int      replays;
    int      cycles;
    bit      hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("remote_control_pulse_tx_channels_core verification failed");
            $finish;
        end
    end

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h (cycle %0d)", field, got, want, cycles);
        mismatches++;
    endtask

    function automatic void push_result(bit kind, logic [31:0] rd, logic [31:0] word,
                                        logic [2:0] ch, bit last);
        result_t r;
        r.kind = kind;
        r.read_data = rd;
        r.tx_word = word;
        r.tx_channel = ch;
        r.irq = irq_line;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void send_burst(int c);
        logic [31:0] end_bit;
        logic [31:0] thr_bit;
        logic [31:0] size;
        logic [31:0] lim;
        logic [31:0] idx;
        logic [31:0] v;
        end_bit = 32'd1 << (TX_END_BIT * c);
        thr_bit = 32'd1 << (THRESH_BIT + c);
        if ((int_raw & (end_bit | thr_bit)) != 0)
        begin
            send_deferred = 1'b1;
            return;
        end
        send_deferred = 1'b0;
        size = 32'(conf_a[c][27:24]) * 64;
        if (size == 0)
            size = 64;
        lim = (burst_lim[c] > BURST_CAP) ? BURST_CAP : burst_lim[c];
        for (int i = 0; i < lim; i++)
        begin
            idx = (((send_offset + 32'(i)) % size) + 32'(64 * c)) % MEM_DEPTH;
            v = pulse_mem[idx];
            if (v == 0)
            begin
                int_raw = (int_raw | end_bit) & ~thr_bit;
                send_offset = 0;
                conf_b[c][0] = 1'b0;
                if ((int_ena & end_bit) != 0)
                    irq_line = 1'b1;
                return;
            end
            push_result(1'b1, 32'd0, v, 3'(c), 1'b0);
            words_sent++;
        end
        send_offset = send_offset + lim;
        int_raw = int_raw | thr_bit;
        if ((int_ena & thr_bit) != 0)
            irq_line = 1'b1;
    endfunction

    function automatic void run_tick();
        for (int c = 0; c < CHANNELS; c++)
            if (conf_b[c][0])
                send_burst(c);
    endfunction

    function automatic logic [31:0] reg_read(logic [11:0] a);
        if (a >= ADDR_CONF && a <= ADDR_CONF + 8 * CHANNELS - 4)
            return a[2] ? conf_b[(a - ADDR_CONF) / 8] : conf_a[(a - ADDR_CONF) / 8];
        if (a == ADDR_INT_RAW)
            return int_raw;
        if (a == ADDR_INT_ST)
            return int_raw & int_ena;
        if (a == ADDR_INT_ENA)
            return int_ena;
        if (a >= ADDR_TX_LIM && a <= ADDR_TX_LIM + 4 * CHANNELS - 1)
            return burst_lim[(a - ADDR_TX_LIM) / 4];
        if (a >= ADDR_MEM)
            return pulse_mem[(a - ADDR_MEM) / 4];
        if (a == ADDR_BUS_CONF)
            return bus_conf;
        return 32'd0;
    endfunction

    function automatic void reg_write(logic [11:0] a, logic [31:0] v);
        if (a >= ADDR_CONF && a <= ADDR_CONF + 8 * CHANNELS - 4)
        begin
            if (!a[2])
                conf_a[(a - ADDR_CONF) / 8] = v;
            else
            begin
                conf_b[(a - ADDR_CONF) / 8] = v;
                if (v[3])
                    send_offset = 0;
            end
        end
        else if (a >= ADDR_TX_LIM && a <= ADDR_TX_LIM + 4 * CHANNELS - 1)
            burst_lim[(a - ADDR_TX_LIM) / 4] = v;
        else if (a == ADDR_INT_ENA)
            int_ena = v;
        else if (a == ADDR_INT_CLR)
        begin
            int_raw = int_raw & ~v;
            if ((int_raw & int_ena) == 0)
                irq_line = 1'b0;
            if (send_deferred)
            begin
                replays++;
                run_tick();
            end
        end
        else if (a >= ADDR_MEM)
            pulse_mem[(a - ADDR_MEM) / 4] = v;
        else if (a == ADDR_BUS_CONF)
            bus_conf = v;
    endfunction

    function automatic void predict_access(bus_op_t item);
        logic [31:0] rd;
        rd = 32'd0;
        if (item.op == OP_READ)
            rd = reg_read(item.addr);
        else if (item.op == OP_WRITE)
            reg_write(item.addr, item.data);
        else if (item.op == OP_TICK)
        begin
            ticks_run++;
            run_tick();
        end
        push_result(1'b0, item.has_rd ? item.rd : rd, 32'd0, 3'd0, 1'b1);
    endfunction

    // response side: check and stall
    int hold_left;
    int stall_phase;

    always @(posedge clk)
    begin
        result_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected transfer", rsp.tx_word, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.kind != want.kind)
                    report("kind", 32'(rsp.kind), 32'(want.kind));
                if (rsp.read_data != want.read_data)
                    report("read_data", rsp.read_data, want.read_data);
                if (rsp.tx_word != want.tx_word)
                    report("tx_word", rsp.tx_word, want.tx_word);
                if (rsp.tx_channel != want.tx_channel)
                    report("tx_channel", 32'(rsp.tx_channel), 32'(want.tx_channel));
                if (rsp.irq != want.irq)
                    report("irq", 32'(rsp.irq), 32'(want.irq));
                if (rsp.last != want.last)
                    report("last", 32'(rsp.last), 32'(want.last));
            end
        end
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (cycles % 300 == 0)
            stall_phase <= $urandom_range(0, 2);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (stall_phase == 0)
            rsp.ready <= 1'b1;
        else if (stall_phase == 1)
            rsp.ready <= ($urandom_range(0, 1) == 1);
        else
            rsp.ready <= (cycles % 7 < 4);
    end

    // request side
    int burst_left;

    task automatic issue(bus_op_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.operation <= item.op;
        req.address <= item.addr;
        req.write_data <= item.data;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_access(item);
    endtask

    function automatic bus_op_t row(logic [1:0] op, logic [11:0] a, logic [31:0] d,
                                    bit has_rd = 0, logic [31:0] rd = 0);
        bus_op_t r;
        r.op = op;
        r.addr = a;
        r.data = d;
        r.has_rd = has_rd;
        r.rd = rd;
        return r;
    endfunction

    function automatic bus_op_t random_op();
        bus_op_t r;
        int pick;
        int c;
        int w;
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, CHANNELS - 1);
        r = row(OP_WRITE, 12'd0, $urandom);
        if (pick < 28)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_DEPTH - 1)
                                            : (64 * c + $urandom_range(0, 15)) % MEM_DEPTH;
            r.addr = ADDR_MEM + 12'(4 * w) + 12'($urandom_range(0, 3));
            if ($urandom_range(0, 6) == 0)
                r.data = 32'd0;
        end
        else if (pick < 34)
        begin
            r.addr = ADDR_CONF + 12'(8 * c) + 12'($urandom_range(0, 3));
            r.data[27:24] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        end
        else if (pick < 42)
        begin
            r.addr = ADDR_CONF + 12'(8 * c + 4) + 12'($urandom_range(0, 3));
            r.data[0] = ($urandom_range(0, 3) != 0);
            r.data[3] = ($urandom_range(0, 3) == 0);
        end
        else if (pick < 48)
        begin
            r.addr = ADDR_TX_LIM + 12'(4 * c) + 12'($urandom_range(0, 3));
            if ($urandom_range(0, 5) != 0)
                r.data = $urandom_range(0, 9);
        end
        else if (pick < 52)
        begin
            r.addr = ADDR_INT_ENA;
            if ($urandom_range(0, 1) == 0)
                r.data = 32'hffff_ffff;
        end
        else if (pick < 62)
        begin
            r.addr = ADDR_INT_CLR;
            if ($urandom_range(0, 1) == 0)
                r.data = 32'hffff_ffff;
        end
        else if (pick < 85)
            r.op = OP_TICK;
        else if (pick < 95)
        begin
            r.op = OP_READ;
            case ($urandom_range(0, 4))
                0: r.addr = ADDR_CONF + 12'($urandom_range(0, 63));
                1: r.addr = ADDR_INT_RAW + 12'(4 * $urandom_range(0, 3));
                2: r.addr = ADDR_TX_LIM + 12'($urandom_range(0, 31));
                3: r.addr = ADDR_MEM + 12'($urandom_range(0, 2047));
                default: r.addr = ADDR_BUS_CONF;
            endcase
        end
        else if (pick < 98)
        begin
            r.op = 2'($urandom);
            r.addr = 12'($urandom);
        end
        else
            r.op = OP_NOP;
        return r;
    endfunction

    bus_op_t directed [] = '{
        row(OP_READ,  ADDR_INT_RAW, 0, 1, 0),
        row(OP_READ,  ADDR_MEM, 0, 1, 0),
        row(OP_READ,  12'hFFF, 0, 1, 0),
        row(OP_WRITE, 12'h004, 32'hffff_ffff),
        row(OP_READ,  12'h004, 0, 1, 0),
        row(OP_WRITE, ADDR_INT_RAW, 32'hffff_ffff),
        row(OP_WRITE, ADDR_INT_ST, 32'hffff_ffff),
        row(OP_READ,  ADDR_INT_RAW, 0, 1, 0),
        row(OP_READ,  ADDR_INT_CLR, 0, 1, 0),
        row(OP_NOP,   12'hABC, 32'h1234_5678, 1, 0),
        row(OP_TICK,  0, 0),
        row(OP_WRITE, ADDR_TX_LIM, 32'hffff_ffff),
        row(OP_READ,  ADDR_TX_LIM + 12'd3, 0, 1, 32'hffff_ffff),
        row(OP_WRITE, ADDR_MEM, 32'hffff_ffff),
        row(OP_WRITE, ADDR_MEM + 12'd4, 32'h0000_0001),
        row(OP_WRITE, ADDR_INT_ENA, 32'hffff_ffff),
        row(OP_WRITE, ADDR_CONF + 12'd4, 32'h0000_0009),
        row(OP_TICK,  0, 0),
        row(OP_READ,  ADDR_INT_ST, 0, 1, 32'h0000_0001),
        row(OP_WRITE, ADDR_CONF + 12'd4, 32'h0000_0001),
        row(OP_TICK,  0, 0),
        row(OP_WRITE, ADDR_INT_CLR, 32'h0000_0001),
        row(OP_WRITE, ADDR_BUS_CONF, 32'ha5a5_a5a5),
        row(OP_READ,  ADDR_BUS_CONF, 0, 1, 32'ha5a5_a5a5),
        row(OP_WRITE, ADDR_CONF + 12'd56, 32'h0f00_0000)
    };

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_READ;
        req.address = '0;
        req.write_data = '0;
        rsp.ready = 1'b0;
        cycles = 0;
        hold_request = 1'b0;
        hold_left = 0;
        stall_phase = 0;
        burst_left = 0;
        int_raw = 0;
        int_ena = 0;
        send_offset = 0;
        bus_conf = 0;
        irq_line = 1'b0;
        send_deferred = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            conf_a[i] = 0;
            conf_b[i] = 0;
            burst_lim[i] = 0;
        end
        for (int i = 0; i < MEM_DEPTH; i++)
            pulse_mem[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            issue(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                hold_request = 1'b1;
            if (n == (RANDOM_ITEMS * 3) / 4)
            begin
                req.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            issue(random_op());
        end
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d accesses, %0d ticks, %0d deferred replays, %0d pulse words checked",
                 directed.size() + RANDOM_ITEMS, ticks_run, replays, words_sent);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("remote_control_pulse_tx_channels_core verification clean");
        else
            $display("remote_control_pulse_tx_channels_core verification failed");
        $finish;
    end
endmodule

// File: files.f
sv/rcptx_pkg.sv
sv/rcptx_if.sv
sv/rcptx_ram.sv
sv/rcptx_modu.sv
sv/remote_control_pulse_tx_channels_core.sv
sv/rcptx_checker.sv
dv/tb.sv
